[design/assert_macros.svh]
// assertion macros shared by the line ending cleanup design
// clock clk_i and active low reset rst_ni are taken from the including scope
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every clock edge outside reset
`define TLEC_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// condition must never be true outside reset
`define TLEC_NEVER(label, cond, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);

`endif

[design/tlec_pkg.sv]
// shared types, constants and helpers for the line ending cleanup design
// no dependencies
`timescale 1ns / 1ps

package tlec_pkg;

  // default blank line allowance
  localparam int MAX_BLANK_LINES_DEF = 1;

  // at most four output bytes per transaction
  localparam int MAX_RES = 4;
  localparam int CNT_W   = $clog2(MAX_RES + 1);
  localparam int IDX_W   = $clog2(MAX_RES);

  // queue between front and back
  localparam int QDEPTH  = 2;
  localparam int QPTR_W  = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int QCNT_W  = $clog2(QDEPTH + 1);

  // configuration register indexes
  typedef enum logic [2:0] {
    REG_STRIP_LEADING  = 3'd0,
    REG_SQUEEZE_BLANK  = 3'd1,
    REG_DOUBLE_SPACE   = 3'd2,
    REG_HALVE_NEWLINES = 3'd3,
    REG_FIX_QUOTES     = 3'd4,
    REG_FORCE_LOWER    = 3'd5
  } reg_idx_e;

  // input kinds
  localparam logic KIND_DATA  = 1'b0;
  localparam logic KIND_FLUSH = 1'b1;

  // byte codes
  localparam logic [7:0] BYTE_EOT   = 8'h04;
  localparam logic [7:0] BYTE_TAB   = 8'h09;
  localparam logic [7:0] BYTE_LF    = 8'h0A;
  localparam logic [7:0] BYTE_CR    = 8'h0D;
  localparam logic [7:0] BYTE_SUB   = 8'h1A;
  localparam logic [7:0] BYTE_SPACE = 8'h20;
  localparam logic [7:0] BYTE_DQUOTE = 8'h22;
  localparam logic [7:0] BYTE_SQUOTE = 8'h27;
  localparam logic [7:0] BYTE_DASH  = 8'h2D;
  localparam logic [7:0] BYTE_UC_A  = 8'h41;
  localparam logic [7:0] BYTE_UC_Z  = 8'h5A;
  localparam logic [7:0] CASE_OFS   = 8'h20;
  localparam logic [7:0] V_DASH_A   = 8'hD0;
  localparam logic [7:0] V_DASH_B   = 8'hD1;
  localparam logic [7:0] V_DQ_A     = 8'h93;
  localparam logic [7:0] V_DQ_B     = 8'h94;
  localparam logic [7:0] V_DQ_C     = 8'hD2;
  localparam logic [7:0] V_DQ_D     = 8'hD3;
  localparam logic [7:0] V_SQ_A     = 8'h92;
  localparam logic [7:0] V_SQ_B     = 8'hD5;

  // configuration bits
  typedef struct packed {
    logic strip_leading;
    logic squeeze_blank;
    logic double_space;
    logic halve_newlines;
    logic fix_vendor_quotes;
    logic force_lower;
  } cfg_t;

  // output bytes caused by one transaction
  typedef struct packed {
    logic [MAX_RES-1:0][7:0] data;
    logic [CNT_W-1:0]        cnt;
  } burst_t;

  // queue status seen by the top level
  typedef struct packed {
    logic full;
    logic empty;
  } qstat_t;

  // append one byte to a burst
  function automatic burst_t add_byte(burst_t b, logic [7:0] v);
    burst_t r;
    r = b;
    if (b.cnt < CNT_W'(MAX_RES)) begin
      r.data[b.cnt[IDX_W-1:0]] = v;
      r.cnt = b.cnt + CNT_W'(1);
    end
    return r;
  endfunction

endpackage

[design/text_line_ending_cleanup_core.sv]
// each accepted burst is queued, then sent through the output byte register
// throughput: one input transaction per cycle while each causes at most one byte
// and the output is not stalled; a burst's bytes go out one after another
// input stalls only when the two-entry burst queue is full
// reset clears line state, configuration, queue and output valid; no clearing pass
`timescale 1ns / 1ps

module text_line_ending_cleanup_core import tlec_pkg::*; #(
  parameter int MAX_BLANK_LINES = MAX_BLANK_LINES_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic [2:0] cfg_idx_i,
  input  logic [0:0] cfg_data_i,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic       kind_i,
  input  logic [7:0] data_byte_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [7:0] out_byte_o,
  output logic       last_o
);

`include "assert_macros.svh"

  cfg_t   cfg_q;
  burst_t burst;
  burst_t head;
  qstat_t qstat;
  logic   accept;
  logic   push;
  logic   pop;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else if (cfg_we_i) begin
      case (reg_idx_e'(cfg_idx_i))
        REG_STRIP_LEADING:  cfg_q.strip_leading     <= cfg_data_i[0];
        REG_SQUEEZE_BLANK:  cfg_q.squeeze_blank     <= cfg_data_i[0];
        REG_DOUBLE_SPACE:   cfg_q.double_space      <= cfg_data_i[0];
        REG_HALVE_NEWLINES: cfg_q.halve_newlines    <= cfg_data_i[0];
        REG_FIX_QUOTES:     cfg_q.fix_vendor_quotes <= cfg_data_i[0];
        REG_FORCE_LOWER:    cfg_q.force_lower       <= cfg_data_i[0];
        default:            cfg_q <= cfg_q;
      endcase
    end
  end

  // input transaction handshake
  assign in_stall_o = qstat.full;
  assign accept     = in_valid_i && !in_stall_o;

  tlec_front #(
    .MAX_BLANK_LINES(MAX_BLANK_LINES)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .accept_i    (accept),
    .kind_i      (kind_i),
    .data_byte_i (data_byte_i),
    .push_o      (push),
    .burst_o     (burst)
  );

  tlec_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .wdata_i (burst),
    .pop_i   (pop),
    .head_o  (head),
    .stat_o  (qstat)
  );

  tlec_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .head_i      (head),
    .empty_i     (qstat.empty),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_byte_o  (out_byte_o),
    .last_o      (last_o)
  );

  // queue and engine consistency
  `TLEC_NEVER(a_pop_empty, pop && qstat.empty, "burst popped from empty queue")
  `TLEC_NEVER(a_push_full, push && qstat.full, "burst pushed into full queue")
  `TLEC_ASSERT(a_pop_loads, pop |=> out_valid_o && last_o, "popped burst did not end in last")

endmodule

[design/tlec_front.sv]
// front end: accepts transactions, tracks line state and builds output bursts
// depends on tlec_pkg
`timescale 1ns / 1ps

module tlec_front import tlec_pkg::*; #(
  parameter int MAX_BLANK_LINES = MAX_BLANK_LINES_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  cfg_t       cfg_i,
  input  logic       accept_i,
  input  logic       kind_i,
  input  logic [7:0] data_byte_i,
  output logic       push_o,
  output burst_t     burst_o
);

  localparam int BR_W = $clog2(MAX_BLANK_LINES + 2);
  localparam logic [BR_W-1:0] BR_MAX = BR_W'(MAX_BLANK_LINES);

  typedef enum logic [1:0] {
    MODE_SEARCH = 2'd0,
    MODE_CR     = 2'd1,
    MODE_Z      = 2'd2
  } line_mode_e;

  line_mode_e      mode_q, mode_d;
  logic            als_q, als_d;
  logic            tog_q, tog_d;
  logic [BR_W-1:0] br_q, br_d;
  logic            lr_q, lr_d;

  // next state and output bytes
  always_comb begin
    burst_t     b;
    logic       ok;
    logic [7:0] ch;
    logic       extra;
    b      = '0;
    ok     = !cfg_i.squeeze_blank || (br_q <= BR_MAX);
    ch     = data_byte_i;
    extra  = 1'b0;
    mode_d = mode_q;
    als_d  = als_q;
    tog_d  = tog_q;
    br_d   = br_q;
    lr_d   = lr_q;
    if (kind_i == KIND_FLUSH) begin
      if ((mode_q == MODE_CR || lr_q) && ok) b = add_byte(b, BYTE_LF);
      mode_d = MODE_SEARCH;
      als_d  = 1'b1;
      tog_d  = 1'b0;
      br_d   = '0;
      lr_d   = 1'b0;
    end else if (data_byte_i == BYTE_EOT) begin
      // dropped without effect
    end else if (data_byte_i == BYTE_LF) begin
      lr_d  = 1'b0;
      als_d = 1'b1;
      if (mode_q == MODE_Z) b = add_byte(b, BYTE_SUB);
      mode_d = MODE_SEARCH;
      if ((!tog_q || !cfg_i.halve_newlines) && ok) begin
        b = add_byte(b, BYTE_LF);
        if (cfg_i.double_space) b = add_byte(b, BYTE_LF);
      end
      tog_d = !tog_q;
      if (br_q <= BR_MAX) br_d = br_q + BR_W'(1);
    end else if (data_byte_i == BYTE_CR) begin
      lr_d  = 1'b0;
      als_d = 1'b1;
      tog_d = 1'b0;
      if (mode_q == MODE_Z) begin
        b = add_byte(b, BYTE_SUB);
      end else if (mode_q == MODE_CR) begin
        if (ok) begin
          b = add_byte(b, BYTE_LF);
          if (cfg_i.double_space) b = add_byte(b, BYTE_LF);
        end
        if (br_q <= BR_MAX) br_d = br_q + BR_W'(1);
      end
      mode_d = MODE_CR;
    end else if (data_byte_i == BYTE_SUB) begin
      // blank run clears first, so a pending newline always goes out
      lr_d  = 1'b0;
      tog_d = 1'b0;
      br_d  = '0;
      if (mode_q == MODE_CR) begin
        b = add_byte(b, BYTE_LF);
        if (cfg_i.double_space) b = add_byte(b, BYTE_LF);
      end
      mode_d = MODE_Z;
    end else if ((data_byte_i == BYTE_SPACE || data_byte_i == BYTE_TAB) &&
                 cfg_i.strip_leading && als_q) begin
      lr_d = 1'b0;
    end else begin
      // text byte
      als_d = 1'b0;
      tog_d = 1'b0;
      lr_d  = 1'b1;
      br_d  = '0;
      if (cfg_i.fix_vendor_quotes) begin
        if (ch == V_DASH_A || ch == V_DASH_B) begin
          ch    = BYTE_DASH;
          extra = 1'b1;
        end else if (ch == V_DQ_A || ch == V_DQ_B || ch == V_DQ_C || ch == V_DQ_D) begin
          ch = BYTE_DQUOTE;
        end else if (ch == V_SQ_A || ch == V_SQ_B) begin
          ch = BYTE_SQUOTE;
        end
      end
      if (cfg_i.force_lower && ch >= BYTE_UC_A && ch <= BYTE_UC_Z) ch = ch + CASE_OFS;
      if (mode_q == MODE_Z) begin
        b = add_byte(b, BYTE_SUB);
      end else if (mode_q == MODE_CR) begin
        b = add_byte(b, BYTE_LF);
        if (cfg_i.double_space) b = add_byte(b, BYTE_LF);
      end
      mode_d = MODE_SEARCH;
      b = add_byte(b, ch);
      if (extra) b = add_byte(b, BYTE_DASH);
    end
    burst_o = b;
  end

  assign push_o = accept_i && (burst_o.cnt != '0);

  // line state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= MODE_SEARCH;
      als_q  <= 1'b1;
      tog_q  <= 1'b0;
      br_q   <= '0;
      lr_q   <= 1'b0;
    end else if (accept_i) begin
      mode_q <= mode_d;
      als_q  <= als_d;
      tog_q  <= tog_d;
      br_q   <= br_d;
      lr_q   <= lr_d;
    end
  end

endmodule

[design/tlec_queue.sv]
// small register queue of output bursts between front and back
// depends on tlec_pkg
`timescale 1ns / 1ps

module tlec_queue import tlec_pkg::*; (
  input  logic   clk_i,
  input  logic   rst_ni,
  input  logic   push_i,
  input  burst_t wdata_i,
  input  logic   pop_i,
  output burst_t head_o,
  output qstat_t stat_o
);

  burst_t              mem_q [QDEPTH];
  logic [QPTR_W-1:0]   wptr_q, rptr_q;
  logic [QCNT_W-1:0]   cnt_q;

  assign stat_o.full  = (cnt_q == QCNT_W'(QDEPTH));
  assign stat_o.empty = (cnt_q == '0);
  assign head_o       = mem_q[rptr_q];

  // entry storage
  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wptr_q] <= wdata_i;
  end

  // pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      if (push_i) begin
        wptr_q <= (wptr_q == QPTR_W'(QDEPTH - 1)) ? '0 : wptr_q + QPTR_W'(1);
      end
      if (pop_i) begin
        rptr_q <= (rptr_q == QPTR_W'(QDEPTH - 1)) ? '0 : rptr_q + QPTR_W'(1);
      end
      case ({push_i, pop_i})
        2'b10:   cnt_q <= cnt_q + QCNT_W'(1);
        2'b01:   cnt_q <= cnt_q - QCNT_W'(1);
        default: cnt_q <= cnt_q;
      endcase
    end
  end

endmodule

[design/tlec_back.sv]
// back end: head burst bytes enter the output register one per cycle unless stalled
// depends on tlec_pkg
`timescale 1ns / 1ps

module tlec_back import tlec_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  burst_t     head_i,
  input  logic       empty_i,
  output logic       pop_o,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [7:0] out_byte_o,
  output logic       last_o
);

  logic [IDX_W-1:0] idx_q;
  logic             valid_q;
  logic [7:0]       byte_q;
  logic             last_q;
  logic             adv;
  logic             is_last;

  // output register may be refilled when empty or taken
  assign adv     = !valid_q || !out_stall_i;
  assign is_last = (CNT_W'(idx_q) + CNT_W'(1)) == head_i.cnt;
  assign pop_o   = adv && !empty_i && is_last;

  // output register and byte index within the burst
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      idx_q   <= '0;
    end else if (adv) begin
      valid_q <= !empty_i;
      if (!empty_i) idx_q <= is_last ? '0 : idx_q + IDX_W'(1);
    end
  end

  // payload
  always_ff @(posedge clk_i) begin
    if (adv && !empty_i) begin
      byte_q <= head_i.data[idx_q];
      last_q <= is_last;
    end
  end

  assign out_valid_o = valid_q;
  assign out_byte_o  = byte_q;
  assign last_o      = last_q;

endmodule

[verif/tb_top.sv]
// self-checking testbench for text_line_ending_cleanup_core
// depends on tlec_pkg and the core; predicts the cleaned byte stream in place
`timescale 1ns / 1ps

module tb_top;
  import tlec_pkg::*;

  localparam int BLANK_MAX       = MAX_BLANK_LINES_DEF;
  localparam int SETTLE_CYCLES   = 8;
  localparam int HOLD_CYCLES     = 60;
  localparam int PHASES          = 8;
  localparam int ITEMS_PER_PHASE = 56;
  localparam int CYCLE_LIMIT     = 300000;
  localparam int DIR_ROWS        = 27;

  localparam cfg_t CFG_OFF = '0;
  localparam cfg_t CFG_ALL = '1;

  // line state of the predictor
  typedef enum logic [1:0] {
    LM_SEARCH,
    LM_CR,
    LM_Z
  } line_mode_e;

  // one cleaned byte waiting at the output
  typedef struct packed {
    logic [7:0] value;
    logic       last;
  } out_byte_t;

  // one row of the directed stimulus
  typedef struct packed {
    cfg_t       cfg;
    logic       kind;
    logic [7:0] data;
    logic       typed;    // expectation given in the row itself
    logic       has_out;
    logic [7:0] out;
  } dir_row_t;

  logic       clk_i       = 1'b0;
  logic       rst_ni      = 1'b0;
  logic       cfg_we_i    = 1'b0;
  logic [2:0] cfg_idx_i   = '0;
  logic [0:0] cfg_data_i  = '0;
  logic       in_valid_i  = 1'b0;
  logic       in_stall_o;
  logic       kind_i      = KIND_DATA;
  logic [7:0] data_byte_i = '0;
  logic       out_valid_o;
  logic       out_stall_i = 1'b0;
  logic [7:0] out_byte_o;
  logic       last_o;

  // predictor state and configuration copy
  cfg_t       model_cfg  = CFG_OFF;
  line_mode_e lmode      = LM_SEARCH;
  logic       line_start = 1'b1;
  logic       lf_odd     = 1'b0;
  int         blank_run  = 0;
  logic       last_text  = 1'b0;

  logic [7:0] step_bytes[$];
  out_byte_t  pending_bytes[$];

  int          err_cnt      = 0;
  int unsigned cycle_cnt    = 0;
  int unsigned tx_idle_pct  = 0;
  int unsigned rx_stall_pct = 0;
  int          hold_req_id  = 0;
  int          hold_seen    = 0;
  int          hold_left    = 0;
  logic        prev_was_cr  = 1'b0;

  logic [7:0] vendor_bytes [8] = '{V_DASH_A, V_DASH_B, V_DQ_A, V_DQ_B,
                                   V_DQ_C, V_DQ_D, V_SQ_A, V_SQ_B};

  // directed stimulus: line ending cases with modes off, then every mode on
  dir_row_t dir_table [DIR_ROWS] = '{
    '{CFG_OFF, KIND_DATA,  8'h00,      1'b1, 1'b1, 8'h00},
    '{CFG_OFF, KIND_DATA,  8'hFF,      1'b1, 1'b1, 8'hFF},
    '{CFG_OFF, KIND_DATA,  BYTE_CR,    1'b0, 1'b0, 8'h00},
    '{CFG_OFF, KIND_DATA,  BYTE_CR,    1'b0, 1'b0, 8'h00},
    '{CFG_OFF, KIND_DATA,  BYTE_SUB,   1'b0, 1'b0, 8'h00},
    '{CFG_OFF, KIND_DATA,  BYTE_LF,    1'b0, 1'b0, 8'h00},
    '{CFG_OFF, KIND_DATA,  8'h61,      1'b0, 1'b0, 8'h00},
    '{CFG_OFF, KIND_DATA,  BYTE_CR,    1'b0, 1'b0, 8'h00},
    '{CFG_OFF, KIND_DATA,  8'h62,      1'b0, 1'b0, 8'h00},
    '{CFG_OFF, KIND_DATA,  BYTE_SUB,   1'b0, 1'b0, 8'h00},
    '{CFG_OFF, KIND_DATA,  BYTE_CR,    1'b0, 1'b0, 8'h00},
    '{CFG_OFF, KIND_DATA,  BYTE_EOT,   1'b1, 1'b0, 8'h00},
    '{CFG_OFF, KIND_DATA,  BYTE_SUB,   1'b0, 1'b0, 8'h00},
    '{CFG_OFF, KIND_FLUSH, BYTE_LF,    1'b0, 1'b0, 8'h00},
    '{CFG_OFF, KIND_DATA,  8'h78,      1'b0, 1'b0, 8'h00},
    '{CFG_OFF, KIND_FLUSH, 8'hFF,      1'b1, 1'b1, BYTE_LF},
    '{CFG_ALL, KIND_DATA,  BYTE_SPACE, 1'b0, 1'b0, 8'h00},
    '{CFG_ALL, KIND_DATA,  V_DASH_A,   1'b0, 1'b0, 8'h00},
    '{CFG_ALL, KIND_DATA,  BYTE_UC_A,  1'b0, 1'b0, 8'h00},
    '{CFG_ALL, KIND_DATA,  V_DQ_A,     1'b0, 1'b0, 8'h00},
    '{CFG_ALL, KIND_DATA,  V_SQ_B,     1'b0, 1'b0, 8'h00},
    '{CFG_ALL, KIND_DATA,  BYTE_LF,    1'b0, 1'b0, 8'h00},
    '{CFG_ALL, KIND_DATA,  BYTE_LF,    1'b0, 1'b0, 8'h00},
    '{CFG_ALL, KIND_DATA,  BYTE_LF,    1'b0, 1'b0, 8'h00},
    '{CFG_ALL, KIND_DATA,  BYTE_UC_Z,  1'b0, 1'b0, 8'h00},
    '{CFG_ALL, KIND_DATA,  BYTE_CR,    1'b0, 1'b0, 8'h00},
    '{CFG_ALL, KIND_FLUSH, 8'h00,      1'b1, 1'b1, BYTE_LF}
  };

  text_line_ending_cleanup_core #(
    .MAX_BLANK_LINES(BLANK_MAX)
  ) dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .kind_i     (kind_i),
    .data_byte_i(data_byte_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_byte_o (out_byte_o),
    .last_o     (last_o)
  );

  // 10 ns clock
  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  // run limit
  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // predictor helpers
  function automatic void emit(logic [7:0] b);
    if (step_bytes.size() < MAX_RES) step_bytes.push_back(b);
  endfunction

  function automatic bit blank_allows();
    return !model_cfg.squeeze_blank || blank_run <= BLANK_MAX;
  endfunction

  function automatic void newline_out();
    if (blank_allows()) begin
      emit(BYTE_LF);
      if (model_cfg.double_space) emit(BYTE_LF);
    end
  endfunction

  function automatic void bump_blank();
    if (blank_run <= BLANK_MAX) blank_run++;
  endfunction

  // cleaned bytes caused by one input transaction, left in step_bytes
  function automatic void predict_cleanup(logic k, logic [7:0] b);
    logic [7:0] ch;
    logic       dash;
    step_bytes.delete();
    ch   = b;
    dash = 1'b0;
    if (k == KIND_FLUSH) begin
      if ((lmode == LM_CR || last_text) && blank_allows()) emit(BYTE_LF);
      lmode      = LM_SEARCH;
      line_start = 1'b1;
      lf_odd     = 1'b0;
      blank_run  = 0;
      last_text  = 1'b0;
    end else if (b == BYTE_EOT) begin
      // control-D is dropped, state kept
    end else if (b == BYTE_LF) begin
      last_text  = 1'b0;
      line_start = 1'b1;
      if (lmode == LM_Z) emit(BYTE_SUB);
      lmode = LM_SEARCH;
      if (!lf_odd || !model_cfg.halve_newlines) newline_out();
      lf_odd = !lf_odd;
      bump_blank();
    end else if (b == BYTE_CR) begin
      last_text  = 1'b0;
      line_start = 1'b1;
      lf_odd     = 1'b0;
      if (lmode == LM_Z) begin
        emit(BYTE_SUB);
      end else if (lmode == LM_CR) begin
        newline_out();
        bump_blank();
      end
      lmode = LM_CR;
    end else if (b == BYTE_SUB) begin
      last_text = 1'b0;
      lf_odd    = 1'b0;
      blank_run = 0;
      if (lmode == LM_CR) newline_out();
      lmode = LM_Z;
    end else if ((b == BYTE_SPACE || b == BYTE_TAB) && model_cfg.strip_leading
                 && line_start) begin
      last_text = 1'b0;
    end else begin
      // text byte: quote mapping first, then case folding
      line_start = 1'b0;
      lf_odd     = 1'b0;
      last_text  = 1'b1;
      blank_run  = 0;
      if (model_cfg.fix_vendor_quotes) begin
        if (b == V_DASH_A || b == V_DASH_B) begin
          ch   = BYTE_DASH;
          dash = 1'b1;
        end else if (b inside {V_DQ_A, V_DQ_B, V_DQ_C, V_DQ_D}) begin
          ch = BYTE_DQUOTE;
        end else if (b == V_SQ_A || b == V_SQ_B) begin
          ch = BYTE_SQUOTE;
        end
      end
      if (model_cfg.force_lower && ch >= BYTE_UC_A && ch <= BYTE_UC_Z) ch = ch + CASE_OFS;
      if (lmode == LM_Z) begin
        emit(BYTE_SUB);
      end else if (lmode == LM_CR) begin
        newline_out();
      end
      lmode = LM_SEARCH;
      emit(ch);
      if (dash) emit(BYTE_DASH);
    end
  endfunction

  // drive one input transaction, record its expected bytes, then maybe idle
  task automatic offer_item(logic k, logic [7:0] b, logic typed, logic has_out,
                            logic [7:0] typed_byte);
    in_valid_i  <= 1'b1;
    kind_i      <= k;
    data_byte_i <= b;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    predict_cleanup(k, b);
    if (typed) begin
      if (has_out) pending_bytes.push_back('{typed_byte, 1'b1});
    end else begin
      foreach (step_bytes[i])
        pending_bytes.push_back('{step_bytes[i], i == step_bytes.size() - 1});
    end
    while ($urandom_range(99) < tx_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
  endtask

  // stop sending and let every expected byte come out
  task automatic wait_drained();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending_bytes.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // write every register index, unused ones included
  task automatic program_regs(cfg_t c);
    logic [2:0] idx;
    logic       v;
    for (int i = 0; i < (1 << $bits(cfg_idx_i)); i++) begin
      idx = i[2:0];
      case (reg_idx_e'(idx))
        REG_STRIP_LEADING:  v = c.strip_leading;
        REG_SQUEEZE_BLANK:  v = c.squeeze_blank;
        REG_DOUBLE_SPACE:   v = c.double_space;
        REG_HALVE_NEWLINES: v = c.halve_newlines;
        REG_FIX_QUOTES:     v = c.fix_vendor_quotes;
        REG_FORCE_LOWER:    v = c.force_lower;
        default:            v = 1'($urandom_range(1));
      endcase
      cfg_we_i   <= 1'b1;
      cfg_idx_i  <= idx;
      cfg_data_i <= v;
      @(posedge clk_i);
    end
    cfg_we_i  <= 1'b0;
    model_cfg = c;
  endtask

  // mostly text-like bytes with line endings, vendor bytes and flushes mixed in
  task automatic pick_item(output logic k, output logic [7:0] b);
    int unsigned sel;
    sel = $urandom_range(99);
    k   = KIND_DATA;
    b   = 8'($urandom_range(255));
    if (prev_was_cr && $urandom_range(1) == 0) begin
      b = BYTE_LF;
    end else if (sel < 6) begin
      k = KIND_FLUSH;
    end else if (sel < 16) begin
      b = BYTE_LF;
    end else if (sel < 26) begin
      b = BYTE_CR;
    end else if (sel < 30) begin
      b = BYTE_SUB;
    end else if (sel < 33) begin
      b = BYTE_EOT;
    end else if (sel < 43) begin
      b = ($urandom_range(1) == 0) ? BYTE_SPACE : BYTE_TAB;
    end else if (sel < 53) begin
      b = vendor_bytes[$urandom_range(7)];
    end else if (sel < 63) begin
      b = BYTE_UC_A + 8'($urandom_range(25));
    end else if (sel < 85) begin
      b = 8'($urandom_range(126, 32));
    end
    prev_was_cr = (k == KIND_DATA && b == BYTE_CR);
  endtask

  // receiver: random stalls, plus a long hold-off when requested
  always @(posedge clk_i) begin
    if (hold_seen != hold_req_id) begin
      hold_seen   <= hold_req_id;
      hold_left   <= HOLD_CYCLES;
      out_stall_i <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left   <= hold_left - 1;
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= ($urandom_range(99) < rx_stall_pct);
    end
  end

  // compare each output transaction with the oldest expected byte
  always @(posedge clk_i) begin
    out_byte_t exp_b;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_bytes.size() == 0) begin
        $error("unexpected output byte %h (last %b)", out_byte_o, last_o);
        err_cnt++;
      end else begin
        exp_b = pending_bytes.pop_front();
        if (out_byte_o !== exp_b.value) begin
          $error("out_byte mismatch: expected %h, actual %h", exp_b.value, out_byte_o);
          err_cnt++;
        end
        if (last_o !== exp_b.last) begin
          $error("last mismatch: expected %b, actual %b", exp_b.last, last_o);
          err_cnt++;
        end
      end
    end
  end

  // stimulus
  initial begin
    logic       k;
    logic [7:0] b;
    cfg_t       next_cfg;

    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed table
    foreach (dir_table[r]) begin
      if (dir_table[r].cfg != model_cfg) begin
        wait_drained();
        program_regs(dir_table[r].cfg);
      end
      offer_item(dir_table[r].kind, dir_table[r].data, dir_table[r].typed,
                 dir_table[r].has_out, dir_table[r].out);
    end

    // random phases, each with its own settings and idle pattern
    for (int p = 0; p < PHASES; p++) begin
      wait_drained();
      case (p)
        0:       next_cfg = CFG_ALL;
        1:       next_cfg = CFG_OFF;
        default: next_cfg = cfg_t'(6'($urandom_range(63)));
      endcase
      program_regs(next_cfg);
      case (p % 4)
        0: begin
          tx_idle_pct  = 0;
          rx_stall_pct = 0;
        end
        1: begin
          tx_idle_pct  = 77;
          rx_stall_pct = 0;
        end
        2: begin
          tx_idle_pct  = 0;
          rx_stall_pct = 77;
        end
        default: begin
          tx_idle_pct  = 36;
          rx_stall_pct = 36;
        end
      endcase
      // long output hold-off while the sender keeps going, so the input backs up
      if (p == 0) hold_req_id++;
      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        pick_item(k, b);
        offer_item(k, b, 1'b0, 1'b0, 8'h00);
      end
    end

    wait_drained();
    if (err_cnt == 0 && pending_bytes.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
